// ----- design/keyframe_int_lerp_sampler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Keyframe sampler assertion macros
// Shared property wrappers for the keyframe sampler; clock and reset are
// passed in so the macros stay free of hidden names.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_INT_LERP_SAMPLER_TOP_ASSERT_SVH
`define KEYFRAME_INT_LERP_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define KFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyframe sampler package
// Types, sequencer states and constants shared by the sampler modules.
// ----------------------------------------------------------------------------
package kfl_pkg;

  // default key table depth
  localparam int MAX_KEYS_DEF = 64;

  // item opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // divider widths and step counts
  localparam int REM_W  = 34;
  localparam int DIVR_W = 33;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] MOD_STEPS  = 6'd32;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd16;

  // fraction of 1.0 in Q1.16, and the rounding offset
  localparam logic [16:0] FRAC_ONE   = 17'h10000;
  localparam logic [16:0] FRAC_ZERO  = 17'h00000;
  localparam logic signed [50:0] ROUND_HALF = 51'sd32768;

  // one stored key: value in the upper word, time in the lower
  typedef struct packed {
    logic [31:0] kval;
    logic [31:0] ktime;
  } key_t;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [31:0]       dividend;
    logic [DIVR_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // divider answer
  typedef struct packed {
    logic              done;
    logic [31:0]       quotient;
    logic [DIVR_W-1:0] remainder;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_MIN,
    ST_RD_MAX,
    ST_CHK,
    ST_MOD,
    ST_CLAMP,
    ST_SCMP,
    ST_RD_T0,
    ST_RD_T1,
    ST_FRAC,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

// ----- design/kfl_key_mem.sv -----
// ----------------------------------------------------------------------------
// Keyframe store
// Single write port, single registered read port holding time/value pairs.
// ----------------------------------------------------------------------------
module kfl_key_mem #(
  parameter int DEPTH = kfl_pkg::MAX_KEYS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  kfl_pkg::key_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output kfl_pkg::key_t rdata_o
);

  kfl_pkg::key_t mem_q [DEPTH];
  kfl_pkg::key_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/kfl_divider.sv -----
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; serves both the loop wrap and the fraction.
// ----------------------------------------------------------------------------
module kfl_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kfl_pkg::div_req_t req_i,
  output kfl_pkg::div_rsp_t rsp_o
);

  localparam int RW = kfl_pkg::REM_W;
  localparam int DW = kfl_pkg::DIVR_W;

  logic                       busy_q, done_q;
  logic [kfl_pkg::STEP_W-1:0] cnt_q;
  logic [RW-1:0]              rem_q;
  logic [31:0]                num_q;
  logic [31:0]                quot_q;
  logic [DW-1:0]              div_q;

  logic [RW-1:0] rem_sh, rem_nx;
  logic          ge;

  // one restoring step: shift in a dividend bit, trial subtract
  assign rem_sh = {rem_q[RW-2:0], num_q[31]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == kfl_pkg::STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == kfl_pkg::STEP_W'(1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      num_q  <= req_i.dividend;
      div_q  <= req_i.divisor;
      cnt_q  <= req_i.steps;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      num_q  <= {num_q[30:0], 1'b0};
      quot_q <= {quot_q[30:0], ge};
      cnt_q  <= cnt_q - kfl_pkg::STEP_W'(1);
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q[DW-1:0];

endmodule

// ----- design/keyframe_int_lerp_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Keyframe linear interpolation sampler
// Keeps a keyframe table and samples it at a Q16.16 time with linear
// interpolation; a small sequencer drives one key store and one divider.
//
//   channel   dir  payload (low bits first)                 handshake
//   s_axis    in   tdata: time_q16, key_value; tuser: opcode tvalid/tready
//   m_axis    out  tdata: value; tuser: valid_res            tvalid/tready
//   cfg       in   wdata: loop_mode                          valid/ready
//
// Append: the key is written as the item is taken.
// Sample: the length is set by the key scan through the single read port,
// by a wrap division in loop mode and by a fraction division when the time
// lies strictly between two keys, both on the one-bit-per-cycle divider.
// Reset clears the key count, loop mode and the output valid; no clearing pass.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "keyframe_int_lerp_sampler_top_assert.svh"

module keyframe_int_lerp_sampler_top #(
  parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] time_q16, [63:32] key_value
  input  logic        s_axis_tuser_i,   // [0] opcode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic        m_axis_tuser_o,   // [0] valid_res
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_wdata_i       // loop_mode
);

  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int AW    = $clog2(MAX_KEYS);

  kfl_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  key_count_q;
  logic              loop_q;
  logic              m_valid_q, m_vres_q;
  logic [31:0]       m_value_q;

  logic signed [31:0] t_q, tmin_q, tmax_q, t0_q, v0_q;
  logic [CNT_W-1:0]   idx_q;
  logic signed [32:0] dv_q;
  logic [16:0]        f_q;
  logic signed [50:0] prod_q;
  logic               res_vld_q;
  logic [31:0]        res_val_q;

  logic               s_acc, full, out_free;
  logic [AW-1:0]      mem_raddr;
  kfl_pkg::key_t      mem_rdata;
  kfl_pkg::div_req_t  div_req;
  kfl_pkg::div_rsp_t  div_rsp;

  logic [CNT_W-1:0]   cnt_m1, idx_m1, idx_inc, idx_fin;
  logic signed [31:0] rd_time, rd_val, t_wrap, t_clamp;
  logic [31:0]        t_mag, rem32;
  logic               scan_go, t1_gt, d_le0, d_ge, need_div;
  logic signed [32:0] span_w, d_w;
  logic signed [50:0] sum_w, sum_sh;

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == kfl_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign full            = (key_count_q == CNT_W'(MAX_KEYS));
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // key store
  kfl_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (s_acc && (s_axis_tuser_i == kfl_pkg::OP_APPEND) && !full),
    .waddr_i (key_count_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared divider
  kfl_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // index arithmetic
  assign cnt_m1  = key_count_q - CNT_W'(1);
  assign idx_m1  = idx_q - CNT_W'(1);
  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_fin = (idx_q == '0) ? CNT_W'(1) :
                   (idx_q >= key_count_q) ? cnt_m1 : idx_q;

  assign rd_time = $signed(mem_rdata.ktime);
  assign rd_val  = $signed(mem_rdata.kval);

  // loop wrap: floor-modulo from the magnitude remainder
  assign t_mag  = t_q[31] ? (~t_q + 32'd1) : t_q;
  assign rem32  = div_rsp.remainder[31:0];
  assign t_wrap = (t_q[31] && (rem32 != '0)) ? (tmax_q - $signed(rem32)) : $signed(rem32);

  // clamp to first key time .. last key time minus one LSB
  assign t_clamp = (t_q < tmin_q) ? tmin_q :
                   (t_q >= tmax_q) ? (tmax_q - 32'sd1) : t_q;

  // scan continues while the key lies at or below the time
  assign scan_go = (idx_q < key_count_q) && (rd_time <= t_q);

  // fraction decision on the surrounding pair
  assign span_w   = $signed({rd_time[31], rd_time}) - $signed({t0_q[31], t0_q});
  assign d_w      = $signed({t_q[31], t_q}) - $signed({t0_q[31], t0_q});
  assign t1_gt    = rd_time > t0_q;
  assign d_le0    = d_w <= 33'sd0;
  assign d_ge     = d_w >= span_w;
  assign need_div = t1_gt && !d_le0 && !d_ge;

  // round half up, then floor by 2^16
  assign sum_w  = prod_q + kfl_pkg::ROUND_HALF;
  assign sum_sh = sum_w >>> 16;

  // sequencer: next state, read address, divider requests
  always_comb begin
    state_d   = state_q;
    mem_raddr = '0;
    div_req   = '0;
    unique case (state_q)
      kfl_pkg::ST_IDLE: begin
        if (s_acc && (s_axis_tuser_i == kfl_pkg::OP_SAMPLE)) begin
          state_d = (key_count_q < CNT_W'(2)) ? kfl_pkg::ST_OUT : kfl_pkg::ST_RD_MIN;
        end
      end
      kfl_pkg::ST_RD_MIN: begin
        state_d = kfl_pkg::ST_RD_MAX;
      end
      kfl_pkg::ST_RD_MAX: begin
        mem_raddr = cnt_m1[AW-1:0];
        state_d   = kfl_pkg::ST_CHK;
      end
      kfl_pkg::ST_CHK: begin
        if (rd_time <= 32'sd0) begin
          state_d = kfl_pkg::ST_OUT;
        end else if (loop_q) begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = t_mag;
          div_req.divisor  = {1'b0, mem_rdata.ktime};
          div_req.steps    = kfl_pkg::MOD_STEPS;
          state_d          = kfl_pkg::ST_MOD;
        end else begin
          state_d = kfl_pkg::ST_CLAMP;
        end
      end
      kfl_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          state_d = kfl_pkg::ST_CLAMP;
        end
      end
      kfl_pkg::ST_CLAMP: begin
        state_d = kfl_pkg::ST_SCMP;
      end
      kfl_pkg::ST_SCMP: begin
        mem_raddr = idx_inc[AW-1:0];
        if (!scan_go) begin
          state_d = kfl_pkg::ST_RD_T0;
        end
      end
      kfl_pkg::ST_RD_T0: begin
        mem_raddr = idx_m1[AW-1:0];
        state_d   = kfl_pkg::ST_RD_T1;
      end
      kfl_pkg::ST_RD_T1: begin
        mem_raddr = idx_q[AW-1:0];
        state_d   = kfl_pkg::ST_FRAC;
      end
      kfl_pkg::ST_FRAC: begin
        if (need_div) begin
          div_req.start    = 1'b1;
          div_req.rem_init = kfl_pkg::REM_W'(unsigned'(d_w));
          div_req.dividend = '0;
          div_req.divisor  = unsigned'(span_w);
          div_req.steps    = kfl_pkg::FRAC_STEPS;
          state_d          = kfl_pkg::ST_DIV;
        end else begin
          state_d = kfl_pkg::ST_MUL;
        end
      end
      kfl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = kfl_pkg::ST_MUL;
        end
      end
      kfl_pkg::ST_MUL: begin
        state_d = kfl_pkg::ST_ADD;
      end
      kfl_pkg::ST_ADD: begin
        state_d = kfl_pkg::ST_OUT;
      end
      kfl_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = kfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kfl_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfl_pkg::ST_IDLE;
      key_count_q <= '0;
      loop_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_acc && (s_axis_tuser_i == kfl_pkg::OP_APPEND) && !full) begin
        key_count_q <= key_count_q + CNT_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        loop_q <= cfg_wdata_i;
      end
      if ((state_q == kfl_pkg::ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kfl_pkg::ST_IDLE: begin
        if (s_acc) begin
          t_q       <= $signed(s_axis_tdata_i[31:0]);
          res_vld_q <= 1'b0;
          res_val_q <= '0;
        end
      end
      kfl_pkg::ST_RD_MAX: tmin_q <= rd_time;
      kfl_pkg::ST_CHK:    tmax_q <= rd_time;
      kfl_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          t_q <= t_wrap;
        end
      end
      kfl_pkg::ST_CLAMP: begin
        t_q   <= t_clamp;
        idx_q <= '0;
      end
      kfl_pkg::ST_SCMP: begin
        idx_q <= scan_go ? idx_inc : idx_fin;
      end
      kfl_pkg::ST_RD_T1: begin
        t0_q <= rd_time;
        v0_q <= rd_val;
      end
      kfl_pkg::ST_FRAC: begin
        dv_q <= $signed({rd_val[31], rd_val}) - $signed({v0_q[31], v0_q});
        f_q  <= (t1_gt && d_le0) ? kfl_pkg::FRAC_ZERO : kfl_pkg::FRAC_ONE;
      end
      kfl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          f_q <= {1'b0, div_rsp.quotient[15:0]};
        end
      end
      kfl_pkg::ST_MUL: begin
        prod_q <= 51'(dv_q * $signed({1'b0, f_q}));
      end
      kfl_pkg::ST_ADD: begin
        res_vld_q <= 1'b1;
        res_val_q <= v0_q + sum_sh[31:0];
      end
      default: ;
    endcase
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if ((state_q == kfl_pkg::ST_OUT) && out_free) begin
      m_vres_q  <= res_vld_q;
      m_value_q <= res_val_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_value_q;
  assign m_axis_tuser_o  = m_vres_q;

  // checks
  `KFL_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, key_count_q <= CNT_W'(MAX_KEYS), "key count beyond table depth")
  `KFL_ASSERT_NEXT(a_append_count, clk_i, rst_ni, s_acc && (s_axis_tuser_i == kfl_pkg::OP_APPEND) && !full, key_count_q == $past(key_count_q) + CNT_W'(1), "append did not advance key count")
  `KFL_ASSERT_IMPL(a_div_state, clk_i, rst_ni, div_rsp.done, (state_q == kfl_pkg::ST_MOD) || (state_q == kfl_pkg::ST_DIV), "divider finished outside a wait state")
  `KFL_ASSERT_NEXT(a_out_load, clk_i, rst_ni, (state_q == kfl_pkg::ST_OUT) && out_free, m_axis_tvalid_o && (state_q == kfl_pkg::ST_IDLE), "result not presented after sequence end")

endmodule

// ----- sim/kfl_lerp_checker.sv -----
// ----------------------------------------------------------------------------
// Keyframe sampler result checker
// Watches the input, result and configuration channels of the sampler,
// keeps its own key table and loop setting, predicts each sample item and
// compares every delivered result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module kfl_lerp_checker #(
  parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] time_q16, [63:32] key_value
  input  logic        s_axis_tuser_i,   // [0] opcode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [31:0] value
  input  logic        m_axis_tuser_i,   // [0] valid_res
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_wdata_i,      // loop_mode
  input  logic        drain_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        valid_res;
    logic [31:0] value;
  } sample_res_t;

  // shadow key table and setting
  int          key_time [MAX_KEYS];
  int          key_val  [MAX_KEYS];
  int          key_cnt;
  logic        loop_mode;
  sample_res_t expected_samples [$];
  bit          drained;

  // one line per mismatch, printing capped, counting not
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < 40) begin
      $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  // wrap, clamp, key search and rounded lerp of one sample time
  function automatic sample_res_t predict_sample(input logic signed [31:0] t_in);
    sample_res_t res;
    longint      t, tmin, tmax, t0, t1, v0, v1, frac, d, acc;
    int          idx;
    res = '0;
    if (key_cnt < 2) return res;
    tmin = key_time[0];
    tmax = key_time[key_cnt-1];
    if (tmax <= 0) return res;
    t = t_in;
    if (loop_mode) begin
      t = t % tmax;
      if (t < 0) t += tmax;
    end
    if (t < tmin) t = tmin;
    else if (t >= tmax) t = tmax - 1;
    // first key strictly above t, kept inside the table
    idx = 0;
    while (idx < key_cnt && key_time[idx] <= t) idx++;
    if (idx == 0) idx = 1;
    if (idx >= key_cnt) idx = key_cnt - 1;
    t0 = key_time[idx-1];
    t1 = key_time[idx];
    v0 = key_val[idx-1];
    v1 = key_val[idx];
    // Q1.16 fraction, truncated and saturated
    if (t1 > t0) begin
      d = t - t0;
      if (d <= 0) frac = 0;
      else if (d >= t1 - t0) frac = 65536;
      else frac = (d * 65536) / (t1 - t0);
    end else begin
      frac = 65536;
    end
    acc = v0 * 65536 + (v1 - v0) * frac + 32768;
    res.valid_res = 1'b1;
    res.value     = 32'(acc >>> 16);
    return res;
  endfunction

  // channel monitor: results first, then new items
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sample_res_t want;
    if (!rst_ni) begin
      key_cnt      = 0;
      loop_mode    = 1'b0;
      expected_samples.delete();
      fail_count_o = 0;
      pending_o    = 0;
      drained      = 1'b0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result item with nothing outstanding", m_axis_tdata_i, '0);
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tuser_i !== want.valid_res) begin
            report_mismatch("valid_res", {31'b0, m_axis_tuser_i}, {31'b0, want.valid_res});
          end
          if (m_axis_tdata_i !== want.value) begin
            report_mismatch("value", m_axis_tdata_i, want.value);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) loop_mode = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == kfl_pkg::OP_APPEND) begin
          if (key_cnt < MAX_KEYS) begin
            key_time[key_cnt] = s_axis_tdata_i[31:0];
            key_val[key_cnt]  = s_axis_tdata_i[63:32];
            key_cnt++;
          end
        end else begin
          expected_samples.push_back(predict_sample(s_axis_tdata_i[31:0]));
        end
      end
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (expected_samples.size() != 0) begin
          report_mismatch("results never delivered", expected_samples.size(), '0);
        end
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

// ----- sim/tb_keyframe_int_lerp_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Keyframe sampler testbench
// Drives append and sample items into the sampler with random gaps and
// output stalls, switches loop mode between phases while idle, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_keyframe_int_lerp_sampler_top;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 225;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_tvalid, s_tready, s_tuser;
  logic [63:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser;
  logic [31:0] m_tdata;
  logic        cfg_valid, cfg_ready, cfg_wdata;
  logic        drain;
  int          fail_count, pending;
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  int          stall_cycles = 0;
  int          key_times_sent [$];

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  keyframe_int_lerp_sampler_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_wdata_i     (cfg_wdata)
  );

  kfl_lerp_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_wdata_i     (cfg_wdata),
    .drain_i         (drain),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // offer one item, optionally after a short gap, and wait for it to be taken
  task automatic send_item(input logic op, input logic [31:0] t, input logic [31:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {v, t};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == kfl_pkg::OP_APPEND && key_times_sent.size() < kfl_pkg::MAX_KEYS_DEF)
      key_times_sent.push_back(t);
  endtask

  // loop mode write once every result is in and the sequencer has settled
  task automatic write_loop_mode(input logic mode);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: short random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    int          n_items, idx, last_time;
    longint      next_t, lo, hi;
    logic [31:0] t;
    bit          counted;
    rst_n     = 1'b0;
    s_tvalid  = 1'b0;
    s_tuser   = kfl_pkg::OP_APPEND;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_wdata = 1'b0;
    drain     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty and short tables, non-positive last key, clamping
    write_loop_mode(1'b0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h7fff_ffff, 32'h0);
    send_item(kfl_pkg::OP_APPEND, 32'h0000_0100, 32'h8000_0000);   // first key off zero
    send_item(kfl_pkg::OP_SAMPLE, 32'h8000_0000, 32'hffff_ffff);
    send_item(kfl_pkg::OP_APPEND, 32'h0000_0000, 32'h7fff_ffff);   // last key at zero
    send_item(kfl_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0);
    send_item(kfl_pkg::OP_APPEND, 32'hffff_fffb, 32'h0000_0000);   // last key negative
    send_item(kfl_pkg::OP_SAMPLE, 32'h0000_0100, 32'h0);
    send_item(kfl_pkg::OP_APPEND, 32'h0001_0000, 32'h7fff_ffff);
    send_item(kfl_pkg::OP_SAMPLE, 32'h8000_0000, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h7fff_ffff, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0000_8000, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0001_0000, 32'h0);
    send_item(kfl_pkg::OP_APPEND, 32'h0001_0000, 32'h8000_0000);   // repeated key time
    send_item(kfl_pkg::OP_SAMPLE, 32'h0000_ffff, 32'h0);
    send_item(kfl_pkg::OP_APPEND, 32'h0003_0000, 32'hffff_ffff);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0002_0000, 32'h0);

    // directed: wrapping of negative, extreme and multiple-of-period times
    write_loop_mode(1'b1);
    send_item(kfl_pkg::OP_SAMPLE, 32'hffff_ffff, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h8000_0000, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h7fff_ffff, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0003_0000, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0001_0000, 32'h0);
    send_item(kfl_pkg::OP_SAMPLE, 32'h0006_0001, 32'h0);

    // random phases: ascending keys with random values, mostly samples
    for (int ph = 0; ph < 4; ph++) begin
      write_loop_mode(logic'(ph % 2));
      if (ph == 1) hold_req = 1'b1;
      if (ph == 3) quiet = 1'b1;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        idx = $urandom_range(0, 99);
        if (idx < 28 && (key_times_sent.size() < kfl_pkg::MAX_KEYS_DEF || idx < 3)) begin
          counted   = key_times_sent.size() < kfl_pkg::MAX_KEYS_DEF;
          last_time = key_times_sent[$];
          case ($urandom_range(0, 9))
            0:       next_t = last_time;
            1:       next_t = longint'(last_time) + 1;
            2, 3, 4: next_t = longint'(last_time) + longint'($urandom_range(1, 1000));
            5, 6, 7: next_t = longint'(last_time) + longint'($urandom_range(1, 32'h0040_0000));
            8:       next_t = longint'(last_time) + longint'($urandom_range(1, 32'h0400_0000));
            default: begin
              // rare out-of-order key
              if ($urandom_range(0, 3) == 0) next_t = longint'(signed'($urandom));
              else next_t = longint'(last_time) + longint'($urandom_range(1, 32'h0010_0000));
            end
          endcase
          if (next_t > 64'sh7fff_ffff) next_t = 64'sh7fff_ffff;
          send_item(kfl_pkg::OP_APPEND, 32'(next_t), $urandom);
          if (counted) n_items++;
        end else begin
          idx       = $urandom_range(0, key_times_sent.size() - 1);
          last_time = key_times_sent[$];
          case ($urandom_range(0, 7))
            0, 1: t = $urandom;
            2:    t = key_times_sent[idx];
            3:    t = key_times_sent[idx] + (($urandom_range(0, 1) != 0) ? 1 : -1);
            4, 5: t = (last_time > 0) ? $urandom_range(0, last_time) : $urandom;
            6: begin
              // strictly inside a key interval where one exists
              lo = key_times_sent[idx];
              hi = (idx + 1 < key_times_sent.size()) ? key_times_sent[idx+1] : lo;
              if (hi > lo + 1) t = 32'(lo + 1 + longint'($urandom_range(0, 32'(hi - lo - 2))));
              else t = $urandom;
            end
            default: begin
              case ($urandom_range(0, 3))
                0:       t = 32'h8000_0000;
                1:       t = 32'h7fff_ffff;
                2:       t = last_time;
                default: t = last_time - 1;
              endcase
            end
          endcase
          send_item(kfl_pkg::OP_SAMPLE, t, $urandom);
          n_items++;
        end
      end
    end

    // drain and verdict
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    drain = 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
